// File: hdl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants of the touch classifier
// Action codes, field widths and the per-axis travel check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsc_pkg;

   localparam int ACT_W   = 4;
   localparam int ID_W    = 8;
   localparam int COORD_W = 16;
   localparam int TIME_W  = 32;
   localparam int THR_W   = 16;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd25;
   localparam logic [ID_W-1:0]  HOME_BUTTON_ID  = 8'd0;

   typedef enum logic [ACT_W-1:0] {
      ACT_BTN_DOWN  = 4'd0,
      ACT_BTN_UP    = 4'd1,
      ACT_TOUCH     = 4'd2,
      ACT_MOVE      = 4'd3,
      ACT_RELEASE   = 4'd4,
      ACT_SNAPSHOT  = 4'd5,
      ACT_CLEAR     = 4'd6,
      ACT_POP_TAP   = 4'd7,
      ACT_POP_SWIPE = 4'd8,
      ACT_TAKE_HOME = 4'd9,
      ACT_QUERY     = 4'd10
   } act_type;

   // Source of the popped payload shown on a result.
   typedef enum logic [1:0] {
      POP_NONE  = 2'd0,
      POP_TAP   = 2'd1,
      POP_SWIPE = 2'd2,
      POP_HOME  = 2'd3
   } pop_src_type;

   function automatic logic [COORD_W-1:0] axis_gap(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   function automatic logic far_enough(input logic [COORD_W-1:0] from_x,
                                       input logic [COORD_W-1:0] from_y,
                                       input logic [COORD_W-1:0] to_x,
                                       input logic [COORD_W-1:0] to_y,
                                       input logic [THR_W-1:0]   thr);
      return (axis_gap(from_x, to_x) >= thr) || (axis_gap(from_y, to_y) >= thr);
   endfunction

endpackage

// File: hdl/tsc_if.sv
// ----------------------------------------------------------------------------
// tsc_if: event and result channels of the touch classifier
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsc_req_if import tsc_pkg::*;;
   logic               valid;
   logic               ready;
   logic [ACT_W-1:0]   action;
   logic [ID_W-1:0]    contact_id;
   logic [COORD_W-1:0] pos_x;
   logic [COORD_W-1:0] pos_y;
   logic [TIME_W-1:0]  time_ms;

   modport source (output valid, action, contact_id, pos_x, pos_y, time_ms,
                   input ready);
   modport sink   (input valid, action, contact_id, pos_x, pos_y, time_ms,
                   output ready);
endinterface

interface tsc_rsp_if import tsc_pkg::*; #(parameter int HOME_W = 5);
   logic               valid;
   logic               ready;
   logic               popped_valid;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] end_x;
   logic [COORD_W-1:0] end_y;
   logic               hold_valid;
   logic [COORD_W-1:0] hold_x;
   logic [COORD_W-1:0] hold_y;
   logic [TIME_W-1:0]  held_ms;
   logic               activity;
   logic [HOME_W-1:0]  home_pending;

   modport source (output valid, popped_valid, start_x, start_y, end_x, end_y,
                   hold_valid, hold_x, hold_y, held_ms, activity, home_pending,
                   input ready);
   modport sink   (input valid, popped_valid, start_x, start_y, end_x, end_y,
                   hold_valid, hold_x, hold_y, held_ms, activity, home_pending,
                   output ready);
endinterface

// File: hdl/tsc_ram.sv
// ----------------------------------------------------------------------------
// tsc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/touch_tap_swipe_classifier.sv
// ----------------------------------------------------------------------------
// touch_tap_swipe_classifier: tap, swipe, hold and home-press detector
// Takes one touch event or command per transfer and returns one result per
// event. Each event is worked out combinationally and its result lands in
// an output register, so the block takes one event every clock cycle as long
// as the result side keeps taking transfers; a result is valid in the cycle
// after its event is taken. One contact is tracked at a time; it is marked
// moved once travel on either axis reaches swipe_threshold
// (written through csr_wr_en / csr_wr_data, reset 25). Releasing an eligible
// contact queues a swipe or a tap; both queues live in RAMs and drop their
// oldest entry when full. Home presses (button id 0) count up to HOME_LIMIT.
// held_ms is the event time minus the contact start time, modulo 2^32.
// Change the threshold only while no result is outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_tap_swipe_classifier import tsc_pkg::*; #(
   parameter int TAP_DEPTH   = 16,
   parameter int SWIPE_DEPTH = 8,
   parameter int HOME_LIMIT  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data,
   tsc_req_if.sink          req_chan,
   tsc_rsp_if.source        rsp_chan
);

   localparam int TAP_AW   = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
   localparam int TAP_FW   = $clog2(TAP_DEPTH + 1);
   localparam int SWIPE_AW = (SWIPE_DEPTH > 1) ? $clog2(SWIPE_DEPTH) : 1;
   localparam int SWIPE_FW = $clog2(SWIPE_DEPTH + 1);
   localparam int HOME_W   = $clog2(HOME_LIMIT + 1);
   localparam int PT_W     = 2 * COORD_W;

   // Configuration and contact tracking state.
   logic [THR_W-1:0]   thr_ff;
   logic               active_ff, active_in;
   logic               moved_ff, moved_in;
   logic               ok_ff, ok_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [TIME_W-1:0]  press_ff, press_in;
   logic [COORD_W-1:0] origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [COORD_W-1:0] latest_x_ff, latest_x_in, latest_y_ff, latest_y_in;

   // Queue pointers and home tally.
   logic [TAP_AW-1:0]   tap_head_ff, tap_head_in;
   logic [TAP_FW-1:0]   tap_fill_ff, tap_fill_in;
   logic [SWIPE_AW-1:0] swipe_head_ff, swipe_head_in;
   logic [SWIPE_FW-1:0] swipe_fill_ff, swipe_fill_in;
   logic [HOME_W-1:0]   home_ff, home_in;

   // Output register.
   logic               rsp_valid_ff;
   pop_src_type        pop_ff, pop_in;
   logic               hold_ff, hold_in;
   logic [COORD_W-1:0] hold_x_ff, hold_x_in, hold_y_ff, hold_y_in;
   logic [TIME_W-1:0]  held_ff, held_in;
   logic               activity_ff, activity_in;
   logic [HOME_W-1:0]  home_out_ff;

   logic               req_ready;
   logic               req_fire;
   act_type            act;
   logic               owns;
   logic               far;

   logic                tap_push, swipe_push;
   logic                tap_full, swipe_full;
   logic [TAP_AW-1:0]   tap_head_inc;
   logic [SWIPE_AW-1:0] swipe_head_inc;
   logic [TAP_FW:0]     tap_sum, tap_wrap;
   logic [SWIPE_FW:0]   swipe_sum, swipe_wrap;
   logic [TAP_AW-1:0]   tap_wr_addr;
   logic [SWIPE_AW-1:0] swipe_wr_addr;
   logic [PT_W-1:0]     tap_rd_data;
   logic [2*PT_W-1:0]   swipe_rd_data;

   // Take a new event whenever the output register is empty or draining.
   assign req_ready        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready   = req_ready;
   assign req_fire         = req_chan.valid && req_ready;
   assign act              = act_type'(req_chan.action);
   assign owns             = active_ff && (req_chan.contact_id == id_ff);
   assign far              = far_enough(origin_x_ff, origin_y_ff,
                                        req_chan.pos_x, req_chan.pos_y, thr_ff);

   // Ring pointer arithmetic. A full queue overwrites its oldest slot, which
   // is the head, and advances the head past it.
   assign tap_full       = (tap_fill_ff == TAP_FW'(TAP_DEPTH));
   assign swipe_full     = (swipe_fill_ff == SWIPE_FW'(SWIPE_DEPTH));
   assign tap_head_inc   = (tap_head_ff == TAP_AW'(TAP_DEPTH - 1)) ?
                           '0 : tap_head_ff + 1'b1;
   assign swipe_head_inc = (swipe_head_ff == SWIPE_AW'(SWIPE_DEPTH - 1)) ?
                           '0 : swipe_head_ff + 1'b1;
   assign tap_sum        = (TAP_FW+1)'(tap_head_ff) + (TAP_FW+1)'(tap_fill_ff);
   assign swipe_sum      = (SWIPE_FW+1)'(swipe_head_ff) + (SWIPE_FW+1)'(swipe_fill_ff);
   assign tap_wrap       = (tap_sum >= (TAP_FW+1)'(TAP_DEPTH)) ?
                           tap_sum - (TAP_FW+1)'(TAP_DEPTH) : tap_sum;
   assign swipe_wrap     = (swipe_sum >= (SWIPE_FW+1)'(SWIPE_DEPTH)) ?
                           swipe_sum - (SWIPE_FW+1)'(SWIPE_DEPTH) : swipe_sum;
   assign tap_wr_addr    = tap_full ? tap_head_ff : tap_wrap[TAP_AW-1:0];
   assign swipe_wr_addr  = swipe_full ? swipe_head_ff : swipe_wrap[SWIPE_AW-1:0];

   // Next state for one event.
   always_comb begin
      active_in     = active_ff;
      moved_in      = moved_ff;
      ok_in         = ok_ff;
      id_in         = id_ff;
      press_in      = press_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      latest_x_in   = latest_x_ff;
      latest_y_in   = latest_y_ff;
      tap_head_in   = tap_head_ff;
      tap_fill_in   = tap_fill_ff;
      swipe_head_in = swipe_head_ff;
      swipe_fill_in = swipe_fill_ff;
      home_in       = home_ff;
      pop_in        = POP_NONE;
      tap_push      = 1'b0;
      swipe_push    = 1'b0;

      unique case (act)
         ACT_BTN_DOWN: begin
            if (req_chan.contact_id == HOME_BUTTON_ID &&
                home_ff < HOME_W'(HOME_LIMIT)) begin
               home_in = home_ff + 1'b1;
            end
         end
         ACT_TOUCH: begin
            if (!active_ff) begin
               active_in   = 1'b1;
               moved_in    = 1'b0;
               ok_in       = 1'b1;
               id_in       = req_chan.contact_id;
               press_in    = req_chan.time_ms;
               origin_x_in = req_chan.pos_x;
               origin_y_in = req_chan.pos_y;
               latest_x_in = req_chan.pos_x;
               latest_y_in = req_chan.pos_y;
            end
         end
         ACT_MOVE: begin
            if (owns) begin
               latest_x_in = req_chan.pos_x;
               latest_y_in = req_chan.pos_y;
               if (far) begin
                  moved_in = 1'b1;
               end
            end
         end
         ACT_RELEASE: begin
            if (owns) begin
               latest_x_in = req_chan.pos_x;
               latest_y_in = req_chan.pos_y;
               if (ok_ff) begin
                  if (moved_ff || far) begin
                     swipe_push = 1'b1;
                     if (swipe_full) begin
                        swipe_head_in = swipe_head_inc;
                     end else begin
                        swipe_fill_in = swipe_fill_ff + 1'b1;
                     end
                  end else begin
                     tap_push = 1'b1;
                     if (tap_full) begin
                        tap_head_in = tap_head_inc;
                     end else begin
                        tap_fill_in = tap_fill_ff + 1'b1;
                     end
                  end
               end
               active_in = 1'b0;
               moved_in  = 1'b0;
               ok_in     = 1'b0;
               id_in     = '0;
            end
         end
         ACT_SNAPSHOT: begin
            // Restart from the given contact; its release makes no gesture.
            tap_head_in   = '0;
            tap_fill_in   = '0;
            swipe_head_in = '0;
            swipe_fill_in = '0;
            home_in       = '0;
            moved_in      = 1'b0;
            ok_in         = 1'b0;
            active_in     = 1'b1;
            id_in         = req_chan.contact_id;
            origin_x_in   = req_chan.pos_x;
            origin_y_in   = req_chan.pos_y;
            latest_x_in   = req_chan.pos_x;
            latest_y_in   = req_chan.pos_y;
            press_in      = req_chan.time_ms;
         end
         ACT_CLEAR: begin
            active_in     = 1'b0;
            moved_in      = 1'b0;
            ok_in         = 1'b0;
            id_in         = '0;
            press_in      = '0;
            origin_x_in   = '0;
            origin_y_in   = '0;
            latest_x_in   = '0;
            latest_y_in   = '0;
            tap_head_in   = '0;
            tap_fill_in   = '0;
            swipe_head_in = '0;
            swipe_fill_in = '0;
            home_in       = '0;
         end
         ACT_POP_TAP: begin
            if (tap_fill_ff != '0) begin
               pop_in      = POP_TAP;
               tap_head_in = tap_head_inc;
               tap_fill_in = tap_fill_ff - 1'b1;
            end
         end
         ACT_POP_SWIPE: begin
            if (swipe_fill_ff != '0) begin
               pop_in        = POP_SWIPE;
               swipe_head_in = swipe_head_inc;
               swipe_fill_in = swipe_fill_ff - 1'b1;
            end
         end
         ACT_TAKE_HOME: begin
            if (home_ff != '0) begin
               pop_in  = POP_HOME;
               home_in = home_ff - 1'b1;
            end
         end
         default: begin
            // Button up, query and unused codes leave the state alone.
         end
      endcase

      // Result fields reflect the state after this event.
      hold_in     = active_in && !moved_in && ok_in;
      hold_x_in   = hold_in ? latest_x_in : '0;
      hold_y_in   = hold_in ? latest_y_in : '0;
      held_in     = req_chan.time_ms - press_in;
      activity_in = active_in || (tap_fill_in != '0) || (swipe_fill_in != '0) ||
                    (home_in != '0);
   end

   // Queue storage. The read port fetches the head entry on every transfer,
   // so the popped entry shows up together with the rest of the result and
   // holds while the result waits.
   tsc_ram #(
      .WIDTH (PT_W),
      .DEPTH (TAP_DEPTH)
   ) u_tap_ram (
      .clock   (clock),
      .wr_en   (req_fire && tap_push),
      .wr_addr (tap_wr_addr),
      .wr_data ({origin_y_ff, origin_x_ff}),
      .rd_en   (req_fire),
      .rd_addr (tap_head_ff),
      .rd_data (tap_rd_data)
   );

   tsc_ram #(
      .WIDTH (2 * PT_W),
      .DEPTH (SWIPE_DEPTH)
   ) u_swipe_ram (
      .clock   (clock),
      .wr_en   (req_fire && swipe_push),
      .wr_addr (swipe_wr_addr),
      .wr_data ({req_chan.pos_y, req_chan.pos_x, origin_y_ff, origin_x_ff}),
      .rd_en   (req_fire),
      .rd_addr (swipe_head_ff),
      .rd_data (swipe_rd_data)
   );

   // Advance state and load the output register on each event transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= THRESHOLD_RESET;
         active_ff     <= 1'b0;
         moved_ff      <= 1'b0;
         ok_ff         <= 1'b0;
         id_ff         <= '0;
         press_ff      <= '0;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         latest_x_ff   <= '0;
         latest_y_ff   <= '0;
         tap_head_ff   <= '0;
         tap_fill_ff   <= '0;
         swipe_head_ff <= '0;
         swipe_fill_ff <= '0;
         home_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pop_ff        <= POP_NONE;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (req_fire) begin
            active_ff     <= active_in;
            moved_ff      <= moved_in;
            ok_ff         <= ok_in;
            id_ff         <= id_in;
            press_ff      <= press_in;
            origin_x_ff   <= origin_x_in;
            origin_y_ff   <= origin_y_in;
            latest_x_ff   <= latest_x_in;
            latest_y_ff   <= latest_y_in;
            tap_head_ff   <= tap_head_in;
            tap_fill_ff   <= tap_fill_in;
            swipe_head_ff <= swipe_head_in;
            swipe_fill_ff <= swipe_fill_in;
            home_ff       <= home_in;
            pop_ff        <= pop_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload; held while the result waits.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_ff     <= hold_in;
         hold_x_ff   <= hold_x_in;
         hold_y_ff   <= hold_y_in;
         held_ff     <= held_in;
         activity_ff <= activity_in;
         home_out_ff <= home_in;
      end
   end

   // Pick the popped point from the queue that was popped; zero otherwise.
   always_comb begin
      rsp_chan.popped_valid = 1'b1;
      rsp_chan.start_x      = '0;
      rsp_chan.start_y      = '0;
      rsp_chan.end_x        = '0;
      rsp_chan.end_y        = '0;
      unique case (pop_ff)
         POP_NONE: begin
            rsp_chan.popped_valid = 1'b0;
         end
         POP_TAP: begin
            rsp_chan.start_x = tap_rd_data[COORD_W-1:0];
            rsp_chan.start_y = tap_rd_data[PT_W-1:COORD_W];
         end
         POP_SWIPE: begin
            rsp_chan.start_x = swipe_rd_data[COORD_W-1:0];
            rsp_chan.start_y = swipe_rd_data[PT_W-1:COORD_W];
            rsp_chan.end_x   = swipe_rd_data[PT_W+COORD_W-1:PT_W];
            rsp_chan.end_y   = swipe_rd_data[2*PT_W-1:PT_W+COORD_W];
         end
         POP_HOME: begin
            // Home takes carry no point.
         end
         default: begin
            rsp_chan.popped_valid = 1'b0;
         end
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hold_valid   = hold_ff;
   assign rsp_chan.hold_x       = hold_x_ff;
   assign rsp_chan.hold_y       = hold_y_ff;
   assign rsp_chan.held_ms      = held_ff;
   assign rsp_chan.activity     = activity_ff;
   assign rsp_chan.home_pending = home_out_ff;

   // A tap pop from a nonempty queue drops the fill by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && act == ACT_POP_TAP && tap_fill_ff != '0)
      |=> (tap_fill_ff == $past(tap_fill_ff) - 1'b1))
      else $error("tap fill did not drop on pop");

   // Fill counts and home tally never pass their limits.
   assert property (@(posedge clock) disable iff (reset)
      (tap_fill_ff <= TAP_FW'(TAP_DEPTH)) && (swipe_fill_ff <= SWIPE_FW'(SWIPE_DEPTH)) &&
      (home_ff <= HOME_W'(HOME_LIMIT)))
      else $error("queue fill or home tally out of range");

   // A reported hold implies reported activity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && hold_ff) |-> activity_ff)
      else $error("hold reported without activity");

   // A swipe pop only shows up after a transfer that found a pending swipe.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && act == ACT_POP_SWIPE && swipe_fill_ff == '0) |=> (pop_ff == POP_NONE))
      else $error("swipe popped from empty queue");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for touch_tap_swipe_classifier
// Drives touch events and commands over the event channel. A local copy of
// the classifier state predicts one report per accepted event, and every
// report transfer is compared against it field by field. A short directed
// pass covers taps, swipes, home presses, ignored events, snapshot and
// clear. Randomized phases follow, each at its own swipe threshold and with
// its own mix of pops, so the queues overflow and the home count saturates.
// Both channel sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import tsc_pkg::*;

   // Classifier sizes, kept equal to the DUT parameters below.
   localparam int TAP_SLOTS   = 16;
   localparam int SWIPE_SLOTS = 8;
   localparam int HOME_MAX    = 16;
   localparam int HOME_W      = 5;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 6;
   localparam int MAX_GAP       = 7;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 40;
   localparam int RANDOM_ITEMS  = 1620;
   localparam int RANDOM_PHASES = 8;
   localparam int COORD_MAX     = 65535;

   // Top of the 4-bit action field; codes above ACT_QUERY are unused.
   localparam logic [ACT_W-1:0] ACT_CODE_MAX = 4'hF;

   typedef struct packed {
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } point_t;

   typedef struct packed {
      point_t start_pt;
      point_t end_pt;
   } swipe_t;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [ID_W-1:0]    contact_id;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [TIME_W-1:0]  time_ms;
   } touch_ev_t;

   typedef struct packed {
      logic               popped_valid;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic               hold_valid;
      logic [COORD_W-1:0] hold_x;
      logic [COORD_W-1:0] hold_y;
      logic [TIME_W-1:0]  held_ms;
      logic               activity;
      logic [HOME_W-1:0]  home_pending;
   } report_t;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [THR_W-1:0] csr_wr_data;

   tsc_req_if req_bus ();
   tsc_rsp_if #(.HOME_W(HOME_W)) rsp_bus ();

   touch_tap_swipe_classifier #(
      .TAP_DEPTH   (TAP_SLOTS),
      .SWIPE_DEPTH (SWIPE_SLOTS),
      .HOME_LIMIT  (HOME_MAX)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // --------------------------------------------------------------------------
   // Classifier state as the bench sees it
   // --------------------------------------------------------------------------
   logic [THR_W-1:0]  travel_thr;
   logic              finger_down;
   logic              finger_moved;
   logic              gesture_armed;
   logic [ID_W-1:0]   finger_id;
   logic [TIME_W-1:0] touch_start_ms;
   point_t            origin_pt;
   point_t            last_pt;
   point_t            tap_ring [TAP_SLOTS];
   logic [3:0]        tap_rd;
   logic [4:0]        tap_count;
   swipe_t            swipe_ring [SWIPE_SLOTS];
   logic [2:0]        swipe_rd;
   logic [3:0]        swipe_count;
   logic [HOME_W-1:0] home_count;

   // Reports owed by the DUT, oldest first.
   report_t reports_due [$];

   int        mismatch_count = 0;
   int        cycle_count    = 0;
   int        events_sent    = 0;
   int        noise_sent     = 0;
   bit        no_idle        = 1'b0;
   logic [TIME_W-1:0] now_ms = '0;

   // Drop tracking and empty both queues and the home count.
   function automatic void clear_tracking();
      finger_down    = 1'b0;
      finger_moved   = 1'b0;
      gesture_armed  = 1'b0;
      finger_id      = '0;
      touch_start_ms = '0;
      origin_pt      = '0;
      last_pt        = '0;
      tap_rd         = '0;
      tap_count      = '0;
      swipe_rd       = '0;
      swipe_count    = '0;
      home_count     = '0;
   endfunction

   // True once either axis has traveled at least the threshold.
   function automatic logic travel_reached(input point_t a, input point_t b);
      int dx;
      int dy;
      dx = int'(a.x) - int'(b.x);
      dy = int'(a.y) - int'(b.y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return (dx >= int'(travel_thr)) || (dy >= int'(travel_thr));
   endfunction

   // Append a tap; a full ring loses its oldest entry.
   function automatic void push_tap(input point_t p);
      logic [3:0] slot;
      if (tap_count >= TAP_SLOTS) begin
         tap_rd    = tap_rd + 1'b1;
         tap_count = 5'(TAP_SLOTS - 1);
      end
      slot           = tap_rd + tap_count[3:0];
      tap_ring[slot] = p;
      tap_count      = tap_count + 1'b1;
   endfunction

   function automatic void push_swipe(input point_t from_p, input point_t to_p);
      logic [2:0] slot;
      if (swipe_count >= SWIPE_SLOTS) begin
         swipe_rd    = swipe_rd + 1'b1;
         swipe_count = 4'(SWIPE_SLOTS - 1);
      end
      slot                      = swipe_rd + swipe_count[2:0];
      swipe_ring[slot].start_pt = from_p;
      swipe_ring[slot].end_pt   = to_p;
      swipe_count               = swipe_count + 1'b1;
   endfunction

   // Apply one event to the local state and work out the report it produces.
   function automatic report_t classify_event(input touch_ev_t ev);
      report_t r;
      point_t  pt;
      point_t  got_start;
      point_t  got_end;
      logic    owns;
      logic    hold;
      r         = '0;
      got_start = '0;
      got_end   = '0;
      pt.x      = ev.pos_x;
      pt.y      = ev.pos_y;
      owns      = finger_down && (ev.contact_id == finger_id);
      case (ev.action)
         ACT_BTN_DOWN: begin
            // Only the home button counts, and the count saturates.
            if (ev.contact_id == HOME_BUTTON_ID && home_count < HOME_MAX)
               home_count = home_count + 1'b1;
         end
         ACT_TOUCH: begin
            // A second contact while one is tracked is dropped.
            if (!finger_down) begin
               finger_down    = 1'b1;
               finger_moved   = 1'b0;
               gesture_armed  = 1'b1;
               finger_id      = ev.contact_id;
               touch_start_ms = ev.time_ms;
               origin_pt      = pt;
               last_pt        = pt;
            end
         end
         ACT_MOVE: begin
            if (owns) begin
               last_pt = pt;
               if (travel_reached(origin_pt, pt)) finger_moved = 1'b1;
            end
         end
         ACT_RELEASE: begin
            if (owns) begin
               last_pt = pt;
               if (gesture_armed) begin
                  if (finger_moved || travel_reached(origin_pt, pt))
                     push_swipe(origin_pt, pt);
                  else
                     push_tap(origin_pt);
               end
               finger_down   = 1'b0;
               finger_moved  = 1'b0;
               gesture_armed = 1'b0;
               finger_id     = '0;
            end
         end
         ACT_SNAPSHOT: begin
            // Queues and home count empty; the contact is tracked but unarmed.
            tap_rd         = '0;
            tap_count      = '0;
            swipe_rd       = '0;
            swipe_count    = '0;
            home_count     = '0;
            finger_moved   = 1'b0;
            gesture_armed  = 1'b0;
            finger_down    = 1'b1;
            finger_id      = ev.contact_id;
            origin_pt      = pt;
            last_pt        = pt;
            touch_start_ms = ev.time_ms;
         end
         ACT_CLEAR: clear_tracking();
         ACT_POP_TAP: begin
            if (tap_count != 0) begin
               r.popped_valid = 1'b1;
               got_start      = tap_ring[tap_rd];
               tap_rd         = tap_rd + 1'b1;
               tap_count      = tap_count - 1'b1;
            end
         end
         ACT_POP_SWIPE: begin
            if (swipe_count != 0) begin
               r.popped_valid = 1'b1;
               got_start      = swipe_ring[swipe_rd].start_pt;
               got_end        = swipe_ring[swipe_rd].end_pt;
               swipe_rd       = swipe_rd + 1'b1;
               swipe_count    = swipe_count - 1'b1;
            end
         end
         ACT_TAKE_HOME: begin
            if (home_count != 0) begin
               r.popped_valid = 1'b1;
               home_count     = home_count - 1'b1;
            end
         end
         default: ;  // button up, query and unused codes leave state alone
      endcase

      hold           = finger_down && !finger_moved && gesture_armed;
      r.start_x      = got_start.x;
      r.start_y      = got_start.y;
      r.end_x        = got_end.x;
      r.end_y        = got_end.y;
      r.hold_valid   = hold;
      r.hold_x       = hold ? last_pt.x : '0;
      r.hold_y       = hold ? last_pt.y : '0;
      r.held_ms      = ev.time_ms - touch_start_ms;
      r.activity     = finger_down || (tap_count != 0) || (swipe_count != 0) ||
                       (home_count != 0);
      r.home_pending = home_count;
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Channel helpers
   // --------------------------------------------------------------------------
   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Advance the event clock; now and then jump to an arbitrary time.
   function automatic logic [TIME_W-1:0] next_ms();
      if ($urandom_range(0, 49) == 0)
         now_ms = $urandom();
      else
         now_ms = now_ms + $urandom_range(0, 400);
      return now_ms;
   endfunction

   // Offset a coordinate by up to a little more than the threshold, clamped
   // to the screen; sometimes pick any coordinate at all.
   function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] base);
      int span;
      int v;
      if ($urandom_range(0, 7) == 0) return COORD_W'($urandom());
      span = int'(travel_thr) + int'(travel_thr) / 4 + 2;
      v    = int'(base);
      if ($urandom_range(0, 1) != 0)
         v = v + int'($urandom_range(0, span));
      else
         v = v - int'($urandom_range(0, span));
      if (v < 0) v = 0;
      else if (v > COORD_MAX) v = COORD_MAX;
      return COORD_W'(v);
   endfunction

   // Offer one event, hold it until the transfer, then record its report.
   task automatic send_event(input logic [ACT_W-1:0]   action,
                             input logic [ID_W-1:0]    id,
                             input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y,
                             input logic [TIME_W-1:0]  t);
      touch_ev_t ev;
      int        gap;
      ev.action     = action;
      ev.contact_id = id;
      ev.pos_x      = x;
      ev.pos_y      = y;
      ev.time_ms    = t;
      gap           = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= ev.action;
      req_bus.contact_id <= ev.contact_id;
      req_bus.pos_x      <= ev.pos_x;
      req_bus.pos_y      <= ev.pos_y;
      req_bus.time_ms    <= ev.time_ms;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      reports_due.push_back(classify_event(ev));
      events_sent++;
   endtask

   // Stop offering events and wait until every owed report has come back.
   task automatic drain_reports();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         if (mismatch_count < MAX_REPORTS)
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // --------------------------------------------------------------------------
   // Report side: random stalls, and a check of every report transfer
   // --------------------------------------------------------------------------
   int sink_stall = 0;

   always @(posedge clock) begin : report_check
      report_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (reports_due.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $error("report transfer with no event outstanding");
               mismatch_count++;
            end else begin
               want = reports_due.pop_front();
               check_field("popped_valid", want.popped_valid, rsp_bus.popped_valid);
               check_field("start_x", want.start_x, rsp_bus.start_x);
               check_field("start_y", want.start_y, rsp_bus.start_y);
               check_field("end_x", want.end_x, rsp_bus.end_x);
               check_field("end_y", want.end_y, rsp_bus.end_y);
               check_field("hold_valid", want.hold_valid, rsp_bus.hold_valid);
               check_field("hold_x", want.hold_x, rsp_bus.hold_x);
               check_field("hold_y", want.hold_y, rsp_bus.hold_y);
               check_field("held_ms", want.held_ms, rsp_bus.held_ms);
               check_field("activity", want.activity, rsp_bus.activity);
               check_field("home_pending", want.home_pending, rsp_bus.home_pending);
            end
            // draw the stall that follows this transfer
            sink_stall = draw_gap();
         end else if (sink_stall > 0) begin
            sink_stall--;
         end
         rsp_bus.ready <= (sink_stall == 0);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Directed tests
   // --------------------------------------------------------------------------

   // Short hold that stays below the threshold, then a tap and its pop.
   task automatic test_tap_path();
      send_event(ACT_TOUCH, 8'h05, 16'd100, 16'd200, 32'd1000);
      send_event(ACT_QUERY, 8'h00, '0, '0, 32'd1040);
      // 24 pixels on both axes: one short of the threshold, still a hold
      send_event(ACT_MOVE, 8'h05, 16'd124, 16'd176, 32'd1080);
      send_event(ACT_RELEASE, 8'h05, 16'd110, 16'd205, 32'd1100);
      send_event(ACT_POP_TAP, 8'hFF, '1, '1, 32'd1200);
   endtask

   // Swipe by travel, swipe by release distance, pops down to empty.
   task automatic test_swipe_path();
      send_event(ACT_TOUCH, 8'hFF, '0, '0, 32'hFFFF_FFF0);
      // exactly the threshold on x marks the contact moved
      send_event(ACT_MOVE, 8'hFF, 16'd25, '0, 32'hFFFF_FFF8);
      // release lands close, but the contact moved; held time wraps
      send_event(ACT_RELEASE, 8'hFF, 16'd3, 16'd3, 32'd5);
      send_event(ACT_TOUCH, 8'h00, '1, '1, '0);
      // no move at all, the release point alone is far enough
      send_event(ACT_RELEASE, 8'h00, '1, '0, '1);
      send_event(ACT_POP_SWIPE, 8'h00, '0, '0, 32'd20);
      send_event(ACT_POP_SWIPE, 8'h00, '0, '0, 32'd21);
      send_event(ACT_POP_SWIPE, 8'h00, '0, '0, 32'd22);
   endtask

   // Home presses: only button 0 counts; take until empty.
   task automatic test_home_count();
      send_event(ACT_BTN_DOWN, HOME_BUTTON_ID, 16'd7, 16'd7, 32'd30);
      send_event(ACT_BTN_DOWN, 8'hFF, '0, '0, 32'd31);
      send_event(ACT_BTN_UP, HOME_BUTTON_ID, '0, '0, 32'd32);
      send_event(ACT_TAKE_HOME, 8'h00, '1, '1, 32'd33);
      send_event(ACT_TAKE_HOME, 8'h00, '1, '1, 32'd34);
   endtask

   // Second touch, events for a foreign id, unused codes, move with no contact.
   task automatic test_ignored_events();
      send_event(ACT_TOUCH, 8'h03, 16'd500, 16'd500, 32'd100);
      send_event(ACT_TOUCH, 8'h04, 16'd9, 16'd9, 32'd110);
      send_event(ACT_MOVE, 8'h04, 16'd900, 16'd900, 32'd120);
      send_event(ACT_RELEASE, 8'h04, 16'd900, 16'd900, 32'd130);
      send_event(ACT_CODE_MAX, 8'h03, '1, '1, 32'd140);
      send_event(ACT_RELEASE, 8'h03, 16'd500, 16'd500, 32'd150);
      send_event(ACT_MOVE, 8'h03, 16'd600, 16'd600, 32'd160);
   endtask

   // Snapshot empties everything and its contact makes no gesture; clear.
   task automatic test_snapshot_and_clear();
      send_event(ACT_BTN_DOWN, HOME_BUTTON_ID, '0, '0, 32'd200);
      send_event(ACT_SNAPSHOT, 8'h09, 16'd1, 16'd2, 32'd210);
      send_event(ACT_RELEASE, 8'h09, 16'd800, 16'd2, 32'd220);
      send_event(ACT_POP_TAP, 8'h00, '0, '0, 32'd230);
      send_event(ACT_TOUCH, 8'h01, 16'd40, 16'd40, 32'd240);
      send_event(ACT_CLEAR, 8'h00, '0, '0, 32'd250);
   endtask

   // --------------------------------------------------------------------------
   // Random traffic: phases with their own threshold, pop rate and idling
   // --------------------------------------------------------------------------
   task automatic test_random_traffic();
      logic [THR_W-1:0]   thr_value;
      logic [ACT_W-1:0]   act;
      logic [ID_W-1:0]    id;
      logic [COORD_W-1:0] ox;
      logic [COORD_W-1:0] oy;
      int                 pop_pct;
      int                 home_pct;
      int                 pick;
      int                 goal;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       thr_value = THRESHOLD_RESET;
            1:       thr_value = '0;
            2:       thr_value = '1;
            3:       thr_value = 16'd1;
            4:       thr_value = THRESHOLD_RESET;
            5:       thr_value = THR_W'($urandom_range(2, 300));
            default: thr_value = THR_W'($urandom());
         endcase
         if (phase != 0) begin
            // hold the sender until every report is back, then write
            drain_reports();
            csr_wr_en   <= 1'b1;
            csr_wr_data <= thr_value;
            @(posedge clock);
            csr_wr_en   <= 1'b0;
            travel_thr  = thr_value;
         end
         no_idle = (phase == 3 || phase == 6);
         // Almost no pops in two phases so queues overflow and home saturates.
         if (phase == 1 || phase == 2) begin
            pop_pct  = 2;
            home_pct = 40;
         end else begin
            pop_pct  = $urandom_range(10, 50);
            home_pct = 20;
         end
         goal = events_sent - noise_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (events_sent - noise_sent < goal) begin
            if ($urandom_range(0, 99) < 60) begin
               // Well-formed gesture: release any tracked contact first.
               if (finger_down)
                  send_event(ACT_RELEASE, finger_id, nudge(last_pt.x), nudge(last_pt.y),
                             next_ms());
               id = ID_W'($urandom());
               if ($urandom_range(0, 5) == 0)
                  ox = ($urandom_range(0, 1) != 0) ? '1 : '0;
               else
                  ox = COORD_W'($urandom());
               if ($urandom_range(0, 5) == 0)
                  oy = ($urandom_range(0, 1) != 0) ? '1 : '0;
               else
                  oy = COORD_W'($urandom());
               send_event(ACT_TOUCH, id, ox, oy, next_ms());
               repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(0, 9) == 0) begin
                     // stray event from some other finger
                     case ($urandom_range(0, 2))
                        0:       act = ACT_TOUCH;
                        1:       act = ACT_MOVE;
                        default: act = ACT_RELEASE;
                     endcase
                     send_event(act, id + ID_W'($urandom_range(1, 255)), nudge(ox),
                                nudge(oy), next_ms());
                     noise_sent++;
                  end
                  send_event(ACT_MOVE, id, nudge(ox), nudge(oy), next_ms());
               end
               // now and then abandon the contact without a release
               if ($urandom_range(0, 19) != 0)
                  send_event(ACT_RELEASE, id, nudge(ox), nudge(oy), next_ms());
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < pop_pct) begin
                  case ($urandom_range(0, 2))
                     0:       act = ACT_POP_TAP;
                     1:       act = ACT_POP_SWIPE;
                     default: act = ACT_TAKE_HOME;
                  endcase
                  send_event(act, ID_W'($urandom()), COORD_W'($urandom()),
                             COORD_W'($urandom()), next_ms());
               end else if (pick < pop_pct + home_pct) begin
                  id = ($urandom_range(0, 3) != 0) ? HOME_BUTTON_ID : ID_W'($urandom());
                  send_event(ACT_BTN_DOWN, id, COORD_W'($urandom()), COORD_W'($urandom()),
                             next_ms());
               end else if (pick < pop_pct + home_pct + 5) begin
                  send_event(ACT_BTN_UP, ID_W'($urandom()), COORD_W'($urandom()),
                             COORD_W'($urandom()), next_ms());
               end else if (pick < pop_pct + home_pct + 6) begin
                  send_event(ACT_SNAPSHOT, ID_W'($urandom()), COORD_W'($urandom()),
                             COORD_W'($urandom()), next_ms());
               end else if (pick < pop_pct + home_pct + 7) begin
                  send_event(ACT_CLEAR, ID_W'($urandom()), COORD_W'($urandom()),
                             COORD_W'($urandom()), next_ms());
               end else if (pick < pop_pct + home_pct + 15) begin
                  send_event(ACT_QUERY, ID_W'($urandom()), COORD_W'($urandom()),
                             COORD_W'($urandom()), next_ms());
               end else begin
                  // Noise: unused codes, or moves and releases for any id.
                  if ($urandom_range(0, 1) != 0)
                     act = ACT_W'($urandom_range(ACT_QUERY + 1, ACT_CODE_MAX));
                  else
                     act = ($urandom_range(0, 1) != 0) ? ACT_MOVE : ACT_RELEASE;
                  send_event(act, ID_W'($urandom()), COORD_W'($urandom()),
                             COORD_W'($urandom()), $urandom());
                  noise_sent++;
               end
            end
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= '0;
      req_bus.contact_id <= '0;
      req_bus.pos_x      <= '0;
      req_bus.pos_y      <= '0;
      req_bus.time_ms    <= '0;
      clear_tracking();
      travel_thr = THRESHOLD_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_tap_path();
      test_swipe_path();
      test_home_count();
      test_ignored_events();
      test_snapshot_and_clear();
      test_random_traffic();

      drain_reports();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
hdl/tsc_pkg.sv
hdl/tsc_if.sv
hdl/tsc_ram.sv
hdl/touch_tap_swipe_classifier.sv
tb/testbench.sv
